### rtl/core/sclb_pkg.sv
// ----------------------------------------------------------------------------
// sclb_pkg
// Shared widths, register indexes, MAC control word and tap selection for the
// separable convolution line buffer.
// ----------------------------------------------------------------------------
package sclb_pkg;

    localparam int PIX_W      = 16;
    localparam int TAP_W      = 16;
    localparam int HSUM_W     = 22;
    localparam int OUT_W      = 26;
    localparam int OCOL_W     = 10;
    localparam int OROW_W     = 16;
    localparam int PROD_W     = HSUM_W + TAP_W;
    localparam int ACC_W      = 42;
    localparam int FRAC_W     = 14;
    localparam int STEP_W     = 4;
    localparam int KSZ_W      = 4;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_KERNEL_WIDTH = 3'd2,
        CFG_KERNEL_HEIGHT = 3'd3,
        CFG_X_TAPS_LOW   = 3'd4,
        CFG_X_TAPS_HIGH  = 3'd5,
        CFG_Y_TAPS_LOW   = 3'd6,
        CFG_Y_TAPS_HIGH  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic clr;
        logic vld;
    } t_mac_ctl;

    function automatic logic signed [TAP_W-1:0] tap_sel(
        input logic [CFG_DATA_W-1:0] lo,
        input logic [CFG_DATA_W-1:0] hi,
        input logic [2:0]            idx
    );
        logic [CFG_DATA_W-1:0] src;
        src = idx[2] ? hi : lo;
        case (idx[1:0])
            2'd0: tap_sel = src[15:0];
            2'd1: tap_sel = src[31:16];
            2'd2: tap_sel = src[47:32];
            2'd3: tap_sel = src[63:48];
            default: tap_sel = '0;
        endcase
    endfunction

endpackage

### rtl/core/sclb_line_mem.sv
// ----------------------------------------------------------------------------
// sclb_line_mem
// Line store of rounded row sums: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module sclb_line_mem #(
    parameter int DEPTH = 8192,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [sclb_pkg::HSUM_W-1:0] i_wdata,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [sclb_pkg::HSUM_W-1:0] o_rdata
);

    logic signed [sclb_pkg::HSUM_W-1:0] r_mem [0:DEPTH-1];
    logic signed [sclb_pkg::HSUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/sclb_mac.sv
// ----------------------------------------------------------------------------
// sclb_mac
// Shared multiply-accumulate: registered product, then accumulate.
// ----------------------------------------------------------------------------
module sclb_mac (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sclb_pkg::t_mac_ctl                 i_ctl,
    input  logic signed [sclb_pkg::HSUM_W-1:0] i_a,
    input  logic signed [sclb_pkg::TAP_W-1:0]  i_b,
    output logic signed [sclb_pkg::ACC_W-1:0]  o_acc
);

    logic                               r_pvld;
    logic signed [sclb_pkg::PROD_W-1:0] r_prod;
    logic signed [sclb_pkg::ACC_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + {{(sclb_pkg::ACC_W - sclb_pkg::PROD_W){r_prod[sclb_pkg::PROD_W-1]}},
                              r_prod};
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/core/separable_convolution_line_buffer.sv
// ----------------------------------------------------------------------------
// separable_convolution_line_buffer
// Raster-order separable 2-D FIR: horizontal taps over a pixel window, rounded
// row sums in a circular line store, vertical taps down one column.
// ----------------------------------------------------------------------------
// Throughput: one pixel every cycle while its column is left of the kernel; else
// the input waits through S_HMAC, S_HWAIT, S_HWB and, if a result is made, S_VMAC,
// S_VWAIT and S_OUT, where the registered result waits for a free output register;
// one shared multiply-accumulate and the single line store read port set this.
// Reset: synchronous, active low; clears counters, sequencer, output valid and
// configuration to defaults. The line store is not cleared.
// ----------------------------------------------------------------------------
module separable_convolution_line_buffer #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TAPS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [sclb_pkg::IN_TDATA_W-1:0]       i_s_tdata,   // [15:0] pixel_value
    input  logic [0:0]                            i_s_tuser,   // [0] start_of_image
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // [25:0] filtered_value, [35:26] out_column, [51:36] out_row, [55:52] zero
    output logic [sclb_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                                  o_m_tlast,   // last_of_image
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sclb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sclb_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int SW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int MW    = SW + 2;
    localparam int DEPTH = MAX_TAPS * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    localparam int HW = sclb_pkg::HSUM_W;
    localparam int KW = sclb_pkg::KSZ_W;
    localparam int RW = sclb_pkg::IMG_H_W;

    typedef enum logic [2:0] {
        S_IDLE, S_HMAC, S_HWAIT, S_HWB, S_VMAC, S_VWAIT, S_OUT
    } t_state;

    // configuration
    logic [sclb_pkg::IMG_W_W-1:0]    r_cfg_iw;
    logic [RW-1:0]                   r_cfg_ih;
    logic [KW-1:0]                   r_cfg_kw;
    logic [KW-1:0]                   r_cfg_kh;
    logic [sclb_pkg::CFG_DATA_W-1:0] r_xlo, r_xhi, r_ylo, r_yhi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_iw <= sclb_pkg::IMG_W_W'(1024);
            r_cfg_ih <= RW'(1024);
            r_cfg_kw <= KW'(3);
            r_cfg_kh <= KW'(3);
            r_xlo    <= '0;
            r_xhi    <= '0;
            r_ylo    <= '0;
            r_yhi    <= '0;
        end else if (i_cfg_valid) begin
            case (sclb_pkg::t_cfg_idx'(i_cfg_index))
                sclb_pkg::CFG_IMAGE_WIDTH:   r_cfg_iw <= i_cfg_data[sclb_pkg::IMG_W_W-1:0];
                sclb_pkg::CFG_IMAGE_HEIGHT:  r_cfg_ih <= i_cfg_data[RW-1:0];
                sclb_pkg::CFG_KERNEL_WIDTH:  r_cfg_kw <= i_cfg_data[KW-1:0];
                sclb_pkg::CFG_KERNEL_HEIGHT: r_cfg_kh <= i_cfg_data[KW-1:0];
                sclb_pkg::CFG_X_TAPS_LOW:    r_xlo    <= i_cfg_data;
                sclb_pkg::CFG_X_TAPS_HIGH:   r_xhi    <= i_cfg_data;
                sclb_pkg::CFG_Y_TAPS_LOW:    r_ylo    <= i_cfg_data;
                sclb_pkg::CFG_Y_TAPS_HIGH:   r_yhi    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // clamped sizes
    logic [WW-1:0] w_w;
    logic [RW-1:0] w_h;
    logic [KW-1:0] w_kw;
    logic [KW-1:0] w_kh;

    always_comb begin
        if (r_cfg_iw == '0) begin
            w_w = WW'(1);
        end else if (32'(r_cfg_iw) > MAX_WIDTH) begin
            w_w = WW'(MAX_WIDTH);
        end else begin
            w_w = WW'(r_cfg_iw);
        end
        w_h = (r_cfg_ih == '0) ? RW'(1) : r_cfg_ih;
        if (r_cfg_kw == '0) begin
            w_kw = KW'(1);
        end else if (32'(r_cfg_kw) > MAX_TAPS) begin
            w_kw = KW'(MAX_TAPS);
        end else begin
            w_kw = r_cfg_kw;
        end
        if (r_cfg_kh == '0) begin
            w_kh = KW'(1);
        end else if (32'(r_cfg_kh) > MAX_TAPS) begin
            w_kh = KW'(MAX_TAPS);
        end else begin
            w_kh = r_cfg_kh;
        end
    end

    // sequencer registers
    t_state                      r_state;
    logic [sclb_pkg::STEP_W-1:0] r_step;
    logic                        r_vdo;
    logic                        r_last;
    logic [CW-1:0]               r_col_cnt, n_col_cnt;
    logic [RW-1:0]               r_row_cnt, n_row_cnt;
    logic [SW-1:0]               r_slot_cnt, n_slot_cnt;
    logic                        r_m_tvalid;
    logic [sclb_pkg::OUT_TDATA_W-1:0] r_m_tdata;
    logic                        r_m_tlast;

    // item payload
    logic [CW-1:0]               r_col;
    logic [RW-1:0]               r_row;
    logic [SW-1:0]               r_cslot;
    logic signed [HW-1:0]        r_rs;
    logic [sclb_pkg::PIX_W-1:0]  r_win [0:MAX_TAPS-1];

    logic          w_s_acc;
    logic [CW-1:0] w_col;
    logic [RW-1:0] w_row;
    logic [SW-1:0] w_slot;
    logic          w_hdo;
    logic          w_vdo;
    logic          w_last_col;
    logic          w_last_row;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid & o_s_tready;

    always_comb begin
        w_col  = i_s_tuser[0] ? '0 : r_col_cnt;
        w_row  = i_s_tuser[0] ? '0 : r_row_cnt;
        w_slot = i_s_tuser[0] ? '0 : r_slot_cnt;
        if (WW'(w_col) >= w_w) begin
            w_col = '0;
        end
        if (w_row >= w_h) begin
            w_row = '0;
        end
        w_last_col = (WW'(w_col) + WW'(1) >= w_w);
        w_last_row = ((RW + 1)'(w_row) + (RW + 1)'(1) >= (RW + 1)'(w_h));
        w_hdo = (WW'(w_col) + WW'(1) >= WW'(w_kw));
        w_vdo = ((RW + 1)'(w_row) + (RW + 1)'(1) >= (RW + 1)'(w_kh))
              && (WW'(w_kw) <= w_w) && (RW'(w_kh) <= w_h);
        n_col_cnt  = w_col + CW'(1);
        n_row_cnt  = w_row;
        n_slot_cnt = w_slot;
        if (w_last_col) begin
            n_col_cnt = '0;
            if (w_last_row) begin
                n_row_cnt  = '0;
                n_slot_cnt = '0;
            end else begin
                n_row_cnt  = w_row + RW'(1);
                n_slot_cnt = (32'(w_slot) + 1 >= MAX_TAPS) ? '0 : w_slot + SW'(1);
            end
        end
    end

    // MAC operand select
    sclb_pkg::t_mac_ctl          w_mac_ctl;
    logic signed [HW-1:0]        w_mac_a;
    logic signed [sclb_pkg::TAP_W-1:0] w_mac_b;
    logic signed [sclb_pkg::ACC_W-1:0] w_acc;
    logic signed [sclb_pkg::ACC_W-1:0] w_acc_rnd;
    logic [SW-1:0]               w_win_idx;
    logic [sclb_pkg::STEP_W-1:0] w_fidx;
    logic signed [HW-1:0]        w_mem_rdata;

    assign w_win_idx = SW'(w_kw - KW'(1) - r_step);
    assign w_fidx    = r_step - sclb_pkg::STEP_W'(1);
    assign w_acc_rnd = w_acc + sclb_pkg::ACC_W'(1 << (sclb_pkg::FRAC_W - 1));

    always_comb begin
        w_mac_ctl.clr = w_s_acc || (r_state == S_HWB);
        w_mac_ctl.vld = 1'b0;
        w_mac_a       = $signed({{(HW - sclb_pkg::PIX_W){1'b0}}, r_win[w_win_idx]});
        w_mac_b       = sclb_pkg::tap_sel(r_xlo, r_xhi, r_step[2:0]);
        case (r_state)
            S_HMAC: begin
                w_mac_ctl.vld = 1'b1;
            end
            S_VMAC: begin
                w_mac_ctl.vld = (r_step != '0);
                w_mac_a       = (w_fidx == w_kh - KW'(1)) ? r_rs : w_mem_rdata;
                w_mac_b       = sclb_pkg::tap_sel(r_ylo, r_yhi, w_fidx[2:0]);
            end
            default: ;
        endcase
    end

    sclb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_b     (w_mac_b),
        .o_acc   (w_acc)
    );

    // line store access
    logic                        w_mem_we;
    logic                        w_mem_re;
    logic [AW-1:0]               w_waddr;
    logic [AW-1:0]               w_raddr;
    logic [KW-1:0]               w_back;
    logic [MW-1:0]               w_rslot;
    logic signed [HW-1:0]        w_rs;

    assign w_rs     = w_acc_rnd[sclb_pkg::FRAC_W + HW - 1:sclb_pkg::FRAC_W];
    assign w_mem_we = (r_state == S_HWB);
    assign w_mem_re = (r_state == S_VMAC) && (r_step < w_kh - KW'(1));
    assign w_back   = w_kh - KW'(1) - r_step;
    assign w_waddr  = AW'(32'(r_cslot) * MAX_WIDTH + 32'(r_col));
    assign w_raddr  = AW'(32'(w_rslot) * MAX_WIDTH + 32'(r_col));

    always_comb begin
        w_rslot = MW'(r_cslot) + MW'(MAX_TAPS) - MW'(w_back);
        if (32'(w_rslot) >= MAX_TAPS) begin
            w_rslot = w_rslot - MW'(MAX_TAPS);
        end
    end

    sclb_line_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_rs),
        .i_re    (w_mem_re),
        .i_raddr (w_raddr),
        .o_rdata (w_mem_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            for (int k = MAX_TAPS - 1; k > 0; k--) begin
                r_win[k] <= r_win[k-1];
            end
            r_win[0] <= i_s_tdata[sclb_pkg::PIX_W-1:0];
            r_col    <= w_col;
            r_row    <= w_row;
            r_cslot  <= w_slot;
        end
        if (r_state == S_HWB) begin
            r_rs <= w_rs;
        end
    end

    // sequencer and output register
    logic w_out_load;
    assign w_out_load = (r_state == S_OUT) && (!r_m_tvalid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_vdo      <= 1'b0;
            r_last     <= 1'b0;
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_slot_cnt <= '0;
            r_m_tvalid <= 1'b0;
            r_m_tdata  <= '0;
            r_m_tlast  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        r_col_cnt  <= n_col_cnt;
                        r_row_cnt  <= n_row_cnt;
                        r_slot_cnt <= n_slot_cnt;
                        r_vdo      <= w_vdo;
                        r_last     <= w_last_col && w_last_row;
                        r_step     <= '0;
                        if (w_hdo) begin
                            r_state <= S_HMAC;
                        end
                    end
                end
                S_HMAC: begin
                    if (r_step == sclb_pkg::STEP_W'(w_kw - KW'(1))) begin
                        r_step  <= '0;
                        r_state <= S_HWAIT;
                    end else begin
                        r_step <= r_step + sclb_pkg::STEP_W'(1);
                    end
                end
                S_HWAIT: begin
                    r_state <= S_HWB;
                end
                S_HWB: begin
                    r_step  <= '0;
                    r_state <= r_vdo ? S_VMAC : S_IDLE;
                end
                S_VMAC: begin
                    if (r_step == sclb_pkg::STEP_W'(w_kh)) begin
                        r_step  <= '0;
                        r_state <= S_VWAIT;
                    end else begin
                        r_step <= r_step + sclb_pkg::STEP_W'(1);
                    end
                end
                S_VWAIT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (w_out_load) begin
                r_m_tvalid <= 1'b1;
                r_m_tlast  <= r_last;
                r_m_tdata  <= {
                    {(sclb_pkg::OUT_TDATA_W - sclb_pkg::OUT_W - sclb_pkg::OCOL_W
                      - sclb_pkg::OROW_W){1'b0}},
                    sclb_pkg::OROW_W'(r_row - RW'(w_kh) + RW'(1)),
                    sclb_pkg::OCOL_W'(32'(r_col) - 32'(w_kw) + 1),
                    w_acc_rnd[sclb_pkg::FRAC_W + sclb_pkg::OUT_W - 1:sclb_pkg::FRAC_W]
                };
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tlast  = r_m_tlast;

    // checks
    a_no_work_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !w_hdo) |=> o_s_tready)
        else $error("pixel without row sum did not free the input");

    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_re |-> !w_mem_we)
        else $error("line store read and write in the same cycle");

    a_vert_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_VMAC && r_step == '0) |-> $past(w_mem_we))
        else $error("vertical pass started without a row sum write");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_OUT))
        else $error("result word raised outside the output step");

endmodule

### verif/sclb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sclb_checker
// Watches the pixel, result and register channels of the separable convolution
// line buffer. A local model of the horizontal and vertical filters predicts
// each output word, and every output word is checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module sclb_checker
    import sclb_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_TAPS  = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [0:0]             i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                   i_m_tlast,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending
);

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic [OCOL_W-1:0]       column;
        logic [OROW_W-1:0]       row;
        logic                    last;
    } t_conv_pixel;

    logic [IMG_W_W-1:0]         cfg_width;
    logic [IMG_H_W-1:0]         cfg_height;
    logic [KSZ_W-1:0]           cfg_kw;
    logic [KSZ_W-1:0]           cfg_kh;
    logic [2*CFG_DATA_W-1:0]    x_taps;
    logic [2*CFG_DATA_W-1:0]    y_taps;

    logic [PIX_W-1:0]           recent_pixels [MAX_TAPS];
    logic signed [HSUM_W-1:0]   row_sums [MAX_TAPS*MAX_WIDTH];
    int                         col_pos;
    int                         row_pos;
    int                         slot;

    t_conv_pixel                expected_q [$];
    t_conv_pixel                oldest;
    int                         mismatches = 0;

    // floor((v + 2^13) / 2^14)
    function automatic longint round_half_up(input longint v);
        return (v + 64'sd8192) >>> FRAC_W;
    endfunction

    function automatic longint tap_value(input logic [2*CFG_DATA_W-1:0] taps, input int i);
        logic signed [TAP_W-1:0] t;
        t = taps[TAP_W*i +: TAP_W];
        return longint'(t);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatches++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task automatic convolve_pixel(input logic [PIX_W-1:0] pix, input logic soi);
        int          w;
        int          h;
        int          kw;
        int          kh;
        int          c;
        int          r;
        int          i;
        longint      hsum;
        longint      vsum;
        t_conv_pixel res;

        w  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        h  = (cfg_height == 0) ? 1 : cfg_height;
        kw = (cfg_kw == 0) ? 1 : ((cfg_kw > MAX_TAPS) ? MAX_TAPS : cfg_kw);
        kh = (cfg_kh == 0) ? 1 : ((cfg_kh > MAX_TAPS) ? MAX_TAPS : cfg_kh);

        if (soi) begin
            col_pos = 0;
            row_pos = 0;
            slot    = 0;
        end
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        c = col_pos;
        r = row_pos;

        for (i = MAX_TAPS - 1; i > 0; i--) recent_pixels[i] = recent_pixels[i-1];
        recent_pixels[0] = pix;

        if (c + 1 >= kw) begin
            hsum = 0;
            for (i = 0; i < kw; i++) begin
                hsum += longint'(recent_pixels[kw-1-i]) * tap_value(x_taps, i);
            end
            row_sums[slot*MAX_WIDTH + c] = HSUM_W'(round_half_up(hsum));

            if (r + 1 >= kh && kw <= w && kh <= h) begin
                vsum = 0;
                // tap 0 meets the topmost of the kh buffered rows
                for (i = 0; i < kh; i++) begin
                    vsum += longint'(row_sums[((slot + MAX_TAPS - (kh - 1 - i)) % MAX_TAPS)
                                             * MAX_WIDTH + c]) * tap_value(y_taps, i);
                end
                res.value  = OUT_W'(round_half_up(vsum));
                res.column = OCOL_W'(c - (kw - 1));
                res.row    = OROW_W'(r - (kh - 1));
                res.last   = (c == w - 1) && (r == h - 1);
                expected_q.push_back(res);
            end
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            if (r + 1 >= h) begin
                row_pos = 0;
                slot    = 0;
            end else begin
                row_pos = r + 1;
                slot    = (slot + 1) % MAX_TAPS;
            end
        end else begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width  = 11'd1024;
            cfg_height = 16'd1024;
            cfg_kw     = 4'd3;
            cfg_kh     = 4'd3;
            x_taps     = '0;
            y_taps     = '0;
            col_pos    = 0;
            row_pos    = 0;
            slot       = 0;
            for (int k = 0; k < MAX_TAPS; k++) recent_pixels[k] = '0;
            expected_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("output word with nothing expected", 0,
                                    $signed(i_m_tdata[OUT_W-1:0]));
                end else begin
                    oldest = expected_q.pop_front();
                    if (i_m_tdata[OUT_W-1:0] !== oldest.value)
                        report_mismatch("filtered_value", oldest.value,
                                        $signed(i_m_tdata[OUT_W-1:0]));
                    if (i_m_tdata[OUT_W +: OCOL_W] !== oldest.column)
                        report_mismatch("out_column", oldest.column,
                                        i_m_tdata[OUT_W +: OCOL_W]);
                    if (i_m_tdata[OUT_W+OCOL_W +: OROW_W] !== oldest.row)
                        report_mismatch("out_row", oldest.row,
                                        i_m_tdata[OUT_W+OCOL_W +: OROW_W]);
                    if (i_m_tdata[OUT_TDATA_W-1:OUT_W+OCOL_W+OROW_W] !== '0)
                        report_mismatch("tdata pad", 0,
                                        i_m_tdata[OUT_TDATA_W-1:OUT_W+OCOL_W+OROW_W]);
                    if (i_m_tlast !== oldest.last)
                        report_mismatch("last_of_image", oldest.last, i_m_tlast);
                end
            end

            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IMAGE_WIDTH:   cfg_width  = i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:  cfg_height = i_cfg_data[IMG_H_W-1:0];
                    CFG_KERNEL_WIDTH:  cfg_kw     = i_cfg_data[KSZ_W-1:0];
                    CFG_KERNEL_HEIGHT: cfg_kh     = i_cfg_data[KSZ_W-1:0];
                    CFG_X_TAPS_LOW:    x_taps[CFG_DATA_W-1:0]          = i_cfg_data;
                    CFG_X_TAPS_HIGH:   x_taps[2*CFG_DATA_W-1:CFG_DATA_W] = i_cfg_data;
                    CFG_Y_TAPS_LOW:    y_taps[CFG_DATA_W-1:0]          = i_cfg_data;
                    CFG_Y_TAPS_HIGH:   y_taps[2*CFG_DATA_W-1:CFG_DATA_W] = i_cfg_data;
                    default: ;
                endcase
            end

            if (i_s_tvalid && i_s_tready) convolve_pixel(i_s_tdata[PIX_W-1:0], i_s_tuser[0]);
        end
        o_pending    <= expected_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### verif/tb_separable_convolution_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_separable_convolution_line_buffer
// Streams raster images through the convolution line buffer under a range of
// image and kernel settings, with random idle on both sides, and relies on
// sclb_checker for prediction and comparison of every output word.
// ----------------------------------------------------------------------------
module tb_separable_convolution_line_buffer;
    import sclb_pkg::*;

    localparam int MAX_WIDTH = 1024;
    localparam int MAX_TAPS  = 8;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic [0:0]             i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    int fail_count;
    int pending;
    bit steady = 1'b0;
    int pixels_sent = 0;

    separable_convolution_line_buffer #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    sclb_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_TAPS  (MAX_TAPS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tlast    (o_m_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(0, 99) >= 37);
    end

    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return PIX_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_taps();
        case ($urandom_range(0, 5))
            0: return {4{16'h7FFF}};
            1: return {4{16'h8000}};
            2: return {48'd0, 16'h4000};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic soi);
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid   <= 1'b1;
        i_s_tdata    <= pix;
        i_s_tuser[0] <= soi;
        do @(posedge i_clk); while (!o_s_tready);
        pixels_sent++;
    endtask

    // sender goes quiet until every predicted word is out, then settles
    task automatic stop_and_drain(input int settle);
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input int w, input int h, input int kw, input int kh,
                             input logic [CFG_DATA_W-1:0] xl, input logic [CFG_DATA_W-1:0] xh,
                             input logic [CFG_DATA_W-1:0] yl, input logic [CFG_DATA_W-1:0] yh);
        stop_and_drain(30);
        write_register(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_register(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_register(CFG_KERNEL_WIDTH, CFG_DATA_W'(kw));
        write_register(CFG_KERNEL_HEIGHT, CFG_DATA_W'(kh));
        write_register(CFG_X_TAPS_LOW, xl);
        write_register(CFG_X_TAPS_HIGH, xh);
        write_register(CFG_Y_TAPS_LOW, yl);
        write_register(CFG_Y_TAPS_HIGH, yh);
        i_cfg_valid <= 1'b0;
    endtask

    // cut_at ends the image early, stray_at restarts it mid-stream
    task automatic send_image(input int count, input bit lead_soi,
                              input int cut_at, input int stray_at);
        int n;
        for (n = 0; n < count && n != cut_at; n++) begin
            send_pixel(rand_pixel(), (n == 0 && lead_soi) || n == stray_at);
        end
    endtask

    initial begin
        int  n;
        int  random_start;
        int  w;
        int  h;
        int  kw;
        int  kh;
        int  count;
        int  images;
        int  cut_at;
        int  stray_at;
        bit  lead_soi;
        bit  broken;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // extreme taps and pixels, then wrap past the image end with no start flag
        configure(3, 2, 2, 2, {32'd0, 16'h8000, 16'h7FFF}, {4{16'h8000}},
                  {32'd0, 16'h7FFF, 16'h8000}, {4{16'h7FFF}});
        for (n = 0; n < 6; n++) send_pixel((n % 3 == 1) ? 16'h0000 : 16'hFFFF, n == 0);
        send_image(3, 1'b0, -1, -1);

        // zero sizes clamp to one: every pixel is a last word
        configure(0, 0, 0, 0, {48'd0, 16'h8000}, '1, {48'd0, 16'h7FFF}, '1);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'hFFFF, 1'b0);

        // oversized kernel clamps to eight and exceeds the image: no output
        configure(2, 2, 15, 9, random_taps(), random_taps(), random_taps(), random_taps());
        send_image(4, 1'b1, -1, -1);

        // start flag in the middle of an image
        configure(2, 2, 1, 2, random_taps(), random_taps(), random_taps(), random_taps());
        send_image(2, 1'b1, -1, -1);
        send_image(4, 1'b1, -1, -1);

        // width above range clamps to the line length
        configure(2047, 1, 1, 1, {48'd0, 16'h4000}, '0, {48'd0, 16'h4000}, '0);
        send_image(2, 1'b1, -1, -1);

        // first 560 pixels of one row at full width, tallest image, drained after 300
        configure(MAX_WIDTH, 65535, 0, 0, random_taps(), random_taps(), random_taps(),
                  random_taps());
        for (n = 0; n < 560; n++) begin
            if (n == 300) stop_and_drain(0);
            send_pixel(rand_pixel(), n == 0);
        end

        random_start = pixels_sent;
        while (pixels_sent - random_start < 700) begin
            steady = (pixels_sent - random_start >= 200) && (pixels_sent - random_start < 450);
            w  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            if ($urandom_range(0, 15) == 0) h = $urandom_range(1000, 65535);
            kw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            kh = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            configure(w, h, kw, kh, random_taps(), random_taps(), random_taps(),
                      random_taps());
            count    = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
            images   = $urandom_range(1, 3);
            lead_soi = 1'b1;
            repeat (images) begin
                broken   = ($urandom_range(0, 6) == 0);
                cut_at   = -1;
                stray_at = -1;
                if (count > 200) begin
                    cut_at = $urandom_range(1, 60);
                end else if (broken && count > 1) begin
                    if ($urandom_range(0, 1)) cut_at = $urandom_range(1, count - 1);
                    else stray_at = $urandom_range(1, count - 1);
                end
                send_image(count, lead_soi, cut_at, stray_at);
                lead_soi = broken || (cut_at >= 0) || $urandom_range(0, 1);
            end
        end
        steady = 1'b0;

        stop_and_drain(40);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
